>>> hdl/dis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dis_pkg
// Shared types and codes for the disjoint interval set.
// ----------------------------------------------------------------------------
package dis_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  // Input operation codes
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_RD_LOAD,
    S_OUT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // take input value, rewind read pointer
    logic apply_add; // update table, load add result
    logic rd_load;   // load entry at read pointer into output register
    logic rd_next;   // advance read pointer
  } dis_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_last;  // output register holds final result of the item
  } dis_stat_t;

endpackage

>>> hdl/dis_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dis_datapath
// Interval table in registers with parallel compare, shift insert/merge,
// read pointer and output register.
// ----------------------------------------------------------------------------
module dis_datapath #(
  parameter int MAX_INTERVALS = 64,
  parameter int VALUE_BITS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dis_pkg::dis_cmd_t   cmd_i,
  output dis_pkg::dis_stat_t  stat_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic [2:0]          status_o,
  output logic [VALUE_BITS-1:0] range_start_o,
  output logic [VALUE_BITS-1:0] range_end_o,
  output logic                last_o
);
  import dis_pkg::*;

  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int PW = $clog2(MAX_INTERVALS);

  logic [VALUE_BITS-1:0] start_q [MAX_INTERVALS];
  logic [VALUE_BITS-1:0] end_q   [MAX_INTERVALS];
  logic [CW-1:0]         count_q, count_d;
  logic [PW-1:0]         ptr_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [2:0]            status_q;
  logic [VALUE_BITS-1:0] ostart_q, oend_q;
  logic                  last_q;

  logic [MAX_INTERVALS-1:0] valid, cov, gt, lo_hit, hi_hit, ins_at, gt_below;
  logic has_lo, has_hi, covered, full;
  logic do_merge, do_grow, do_shrink, do_insert;
  status_e add_st;

  // Compare the value against every entry in parallel
  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cmp
    assign valid[i]  = count_q > CW'(i);
    assign cov[i]    = valid[i] && (start_q[i] <= val_q) && (val_q <= end_q[i]);
    assign gt[i]     = valid[i] && (start_q[i] > val_q);
    assign lo_hit[i] = valid[i] &&
                       (({1'b0, end_q[i]} + 1'b1) == {1'b0, val_q});
    assign hi_hit[i] = valid[i] &&
                       (({1'b0, val_q} + 1'b1) == {1'b0, start_q[i]});
    if (i == 0) begin : g_first
      assign gt_below[i] = 1'b0;
    end else begin : g_rest
      assign gt_below[i] = gt[i-1];
    end
    assign ins_at[i] = !gt_below[i] && (gt[i] || (count_q == CW'(i)));
  end

  assign covered = |cov;
  assign has_lo  = |lo_hit;
  assign has_hi  = |hi_hit;
  assign full    = count_q == CW'(MAX_INTERVALS);

  // Decide the add action
  always_comb begin
    do_merge  = 1'b0;
    do_grow   = 1'b0;
    do_shrink = 1'b0;
    do_insert = 1'b0;
    add_st    = ST_ADDED;
    priority if (covered) begin
      add_st = ST_PRESENT;
    end else if (has_lo && has_hi) begin
      do_merge = 1'b1;
    end else if (has_lo) begin
      do_grow = 1'b1;
    end else if (has_hi) begin
      do_shrink = 1'b1;
    end else if (full) begin
      add_st = ST_FULL;
    end else begin
      do_insert = 1'b1;
    end
  end

  // Next interval count
  always_comb begin
    count_d = count_q;
    if (cmd_i.apply_add && do_merge) begin
      count_d = count_q - CW'(1);
    end else if (cmd_i.apply_add && do_insert) begin
      count_d = count_q + CW'(1);
    end
  end

  // Update each table entry from the value or its neighbors
  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_upd
    always_ff @(posedge clk_i) begin
      if (cmd_i.apply_add) begin
        if (do_grow && lo_hit[i]) begin
          end_q[i] <= val_q;
        end
        if (do_shrink && hi_hit[i]) begin
          start_q[i] <= val_q;
        end
        if (do_insert) begin
          if (ins_at[i]) begin
            start_q[i] <= val_q;
            end_q[i]   <= val_q;
          end else if (gt_below[i]) begin
            if (i > 0) begin
              start_q[i] <= start_q[(i > 0) ? i-1 : 0];
              end_q[i]   <= end_q[(i > 0) ? i-1 : 0];
            end
          end
        end
        if (do_merge && (i < MAX_INTERVALS - 1)) begin
          if (lo_hit[i]) begin
            end_q[i] <= end_q[(i < MAX_INTERVALS - 1) ? i+1 : i];
          end else if (gt[i]) begin
            start_q[i] <= start_q[(i < MAX_INTERVALS - 1) ? i+1 : i];
            end_q[i]   <= end_q[(i < MAX_INTERVALS - 1) ? i+1 : i];
          end
        end
      end
    end
  end

  // Hold count and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.capture) begin
        ptr_q <= '0;
      end else if (cmd_i.rd_next) begin
        ptr_q <= ptr_q + PW'(1);
      end
    end
  end

  // Capture value and load output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      val_q <= value_i;
    end
    if (cmd_i.apply_add) begin
      status_q <= add_st;
      ostart_q <= '0;
      oend_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.rd_load) begin
      if (count_q == '0) begin
        status_q <= ST_EMPTY;
        ostart_q <= '0;
        oend_q   <= '0;
        last_q   <= 1'b1;
      end else begin
        status_q <= ST_RANGE;
        ostart_q <= start_q[ptr_q];
        oend_q   <= end_q[ptr_q];
        last_q   <= (CW'(ptr_q) + CW'(1)) == count_q;
      end
    end
  end

  assign stat_o.out_last = last_q;
  assign status_o        = status_q;
  assign range_start_o   = ostart_q;
  assign range_end_o     = oend_q;
  assign last_o          = last_q;

  // Count never exceeds table size
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_INTERVALS))
    else $error("interval count above table size");

  // An add moves the count by at most one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply_add |=> (count_q == $past(count_q)) ||
      (count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)))
    else $error("interval count jumped");

endmodule

>>> hdl/dis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dis_ctrl
// Controller: sequences add updates, readout and the output transfer.
// ----------------------------------------------------------------------------
module dis_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_op_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dis_pkg::dis_cmd_t  cmd_o,
  input  dis_pkg::dis_stat_t stat_i
);
  import dis_pkg::*;

  state_e state_q, state_d;
  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_e'(in_op_i) == OP_ADD) ? S_ADD : S_RD_LOAD;
        end
      end
      S_ADD:     state_d = S_OUT;
      S_RD_LOAD: state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) begin
          state_d = stat_i.out_last ? S_IDLE : S_RD_LOAD;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_ADD:     cmd_o.apply_add = 1'b1;
      S_RD_LOAD: cmd_o.rd_load   = 1'b1;
      S_OUT: begin
        out_valid_o   = 1'b1;
        cmd_o.rd_next = out_ready_i && !stat_i.out_last;
      end
      default: ;
    endcase
  end

  // Input and output never both open
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

  // An accepted item closes the input
  a_close_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input still open after transfer");

  // A final result transfer returns to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && stat_i.out_last) |=> in_ready_o)
    else $error("not idle after final result");

endmodule

>>> hdl/disjoint_interval_set_top.sv
`timescale 1ns / 1ps
// Add: S_IDLE captures the item, S_ADD loads its status into the output
// register and S_OUT holds it; no new item is accepted until it is taken.
// Read: each interval passes through S_RD_LOAD (table read at the single
// read pointer), then S_OUT (output transfer, held while not ready).
// Reset: rst_ni clears the interval count and controller; table contents stay.
// ----------------------------------------------------------------------------
// disjoint_interval_set_top
// Sorted set of disjoint closed intervals with add and readout operations.
// ----------------------------------------------------------------------------
module disjoint_interval_set_top #(
  parameter int MAX_INTERVALS = 64,
  parameter int VALUE_BITS    = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  logic [((VALUE_BITS+7)/8)*8-1:0] s_axis_tdata_i,   // value
  input  logic s_axis_tuser_i,                              // op
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  output logic [((2*VALUE_BITS+7)/8)*8-1:0] m_axis_tdata_o, // range_start, range_end
  output logic [2:0] m_axis_tuser_o,                        // status
  output logic m_axis_tlast_o                               // last
);
  import dis_pkg::*;

  localparam int OW = ((2*VALUE_BITS+7)/8)*8;

  dis_cmd_t  cmd;
  dis_stat_t stat;
  logic [VALUE_BITS-1:0] rs, re;

  dis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  dis_datapath #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .value_i       (s_axis_tdata_i[VALUE_BITS-1:0]),
    .status_o      (m_axis_tuser_o),
    .range_start_o (rs),
    .range_end_o   (re),
    .last_o        (m_axis_tlast_o)
  );

  // Pack results, start in the low bits
  assign m_axis_tdata_o = OW'({re, rs});

endmodule
